[hdl/ecp_pkg.sv]
package ecp_pkg;

   // Field widths shared by the channels and the datapath.
   localparam int COUNT_W = 16;
   localparam int TARGET_W = 16;
   localparam int GAIN_W = 16;
   localparam int DUTY_W = 16;
   localparam int SPEED_W = 17;
   localparam int CSR_IDX_W = 2;

   // Default build parameters.
   localparam int WINDOW_LEN_DEF = 8;
   localparam logic [DUTY_W-1:0] DRIVE_PERIOD_DEF = 16'd60000;

   // Gain values after reset.
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd2;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
   localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

   // Reciprocal of 100 scaled by 2^32, rounded down, for the integral divide.
   localparam logic [25:0] DIV100_RECIP = 26'd42949672;
   localparam logic [33:0] HUNDRED = 34'd100;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PROP_GAIN  = 2'd0,
      REG_INTEG_GAIN = 2'd1,
      REG_DERIV_GAIN = 2'd2
   } reg_index_type;

endpackage

[hdl/ecp_if.sv]
// Input channel: one control tick per item.
interface ecp_req_if import ecp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  encoder_count;
   logic [TARGET_W-1:0] target_speed;

   modport source (output valid, output encoder_count, output target_speed, input ready);
   modport sink (input valid, input encoder_count, input target_speed, output ready);
endinterface

// Result channel: one drive result per tick.
interface ecp_rsp_if import ecp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [DUTY_W-1:0]  duty_level;
   logic               drive_enable;
   logic [SPEED_W-1:0] measured_speed;

   modport source (output valid, output duty_level, output drive_enable,
                   output measured_speed, input ready);
   modport sink (input valid, input duty_level, input drive_enable,
                 input measured_speed, output ready);
endinterface

[hdl/encoder_pid_speed_controller_top.sv]
// Channel    | Direction | Payload                                      | Handshake
// -----------+-----------+----------------------------------------------+------------
// req_chan   | in        | encoder_count[15:0], target_speed[15:0]      | valid/ready
// rsp_chan   | out       | duty_level[15:0], drive_enable, speed[16:0]  | valid/ready
// csr_*      | in        | csr_index[1:0], csr_wdata[15:0]              | csr_we
//
// A nine-stage pipeline takes one item per cycle while the output is not blocked;
// each item passes through stages 0 to 8 in order and is offered from stage 8.
// The stage count is set by the integral divide by 100 and the window mean divide,
// each a reciprocal multiply plus correction.
// Reset clears the gains to their defaults, the controller state and the window.
// Each stage holds only while the one after it is full and blocked, so bubbles
// close up and input is taken while a result waits at the output.
module encoder_pid_speed_controller_top import ecp_pkg::*; #(
   parameter int WINDOW_LEN = WINDOW_LEN_DEF,
   parameter logic [DUTY_W-1:0] DRIVE_PERIOD = DRIVE_PERIOD_DEF
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 csr_we,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [GAIN_W-1:0]    csr_wdata,
   ecp_req_if.sink             req_chan,
   ecp_rsp_if.source           rsp_chan
);

   localparam int NSTG = 9;
   localparam int SUM_W = 16 + $clog2(WINDOW_LEN);
   localparam longint unsigned RECIP_FULL = (64'd1 << SUM_W) / WINDOW_LEN;
   localparam logic [SUM_W:0] RECIP_W = RECIP_FULL[SUM_W:0];
   localparam int REM_W = $clog2(WINDOW_LEN) + 2;
   localparam logic [REM_W-1:0] WL_C = REM_W'(WINDOW_LEN);
   localparam int PROD_W = 2 * SUM_W + 1;

   // Gain registers.
   logic [GAIN_W-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         deriv_gain_ff <= DERIV_GAIN_RST;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_PROP_GAIN: prop_gain_ff <= csr_wdata;
            REG_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            REG_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage occupancy and flow control. A stage is free when empty or when
   // the stage after it is free.
   logic [NSTG-1:0] v_ff, v_in, move;
   logic [NSTG:0]   free;
   logic            req_acc;

   always_comb begin
      free[NSTG] = rsp_chan.ready;
      for (int k = NSTG - 1; k >= 0; k--) begin
         free[k] = !v_ff[k] || free[k+1];
      end
      for (int k = 0; k < NSTG; k++) begin
         move[k] = v_ff[k] && free[k+1];
      end
      req_acc = req_chan.valid && free[0];
      v_in[0] = req_acc || (v_ff[0] && !move[0]);
      for (int k = 1; k < NSTG; k++) begin
         v_in[k] = move[k-1] || (v_ff[k] && !move[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = free[0];

   // Measured speed carried along with each item.
   logic [SPEED_W-1:0] spd_ff [1:NSTG-2];

   // Stage 0: input register.
   logic [COUNT_W-1:0]  s0_count_ff;
   logic [TARGET_W-1:0] s0_target_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s0_count_ff <= req_chan.encoder_count;
         s0_target_ff <= req_chan.target_speed;
      end
   end

   // Stage 1: count difference, speed, error and error change.
   logic [COUNT_W-1:0]  prev_count_ff;
   logic signed [17:0]  prev_err_ff;
   logic [COUNT_W-1:0]  diff, mag;
   logic [SPEED_W-1:0]  speed_in;
   logic signed [17:0]  err_in, err_neg;
   logic signed [18:0]  delta_in;
   logic [16:0]         abs_in;
   logic signed [17:0]  s1_err_ff;
   logic signed [18:0]  s1_delta_ff;
   logic [16:0]         s1_abs_ff;
   logic                s1_neg_ff;

   always_comb begin
      diff = s0_count_ff - prev_count_ff;
      // The half-range jump negates to itself, giving a magnitude of 32768.
      mag = diff[15] ? (~diff + 16'd1) : diff;
      speed_in = {mag, 1'b0} + {1'b0, mag};
      err_in = $signed({2'b00, s0_target_ff}) - $signed({1'b0, speed_in});
      delta_in = {err_in[17], err_in} - {prev_err_ff[17], prev_err_ff};
      err_neg = -err_in;
      abs_in = err_in[17] ? err_neg[16:0] : err_in[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
         prev_err_ff <= '0;
      end else if (move[0]) begin
         prev_count_ff <= s0_count_ff;
         prev_err_ff <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move[0]) begin
         s1_err_ff <= err_in;
         s1_delta_ff <= delta_in;
         s1_abs_ff <= abs_in;
         s1_neg_ff <= err_in[17];
         spd_ff[1] <= speed_in;
      end
   end

   // Stage 2: gain products.
   logic signed [34:0] p_full;
   logic signed [35:0] dp_full;
   logic [32:0]        im_in;
   logic [31:0]        s2_p_ff, s2_dp_ff;
   logic [32:0]        s2_im_ff;
   logic               s2_neg_ff;

   always_comb begin
      p_full = $signed({1'b0, prop_gain_ff}) * s1_err_ff;
      dp_full = $signed({1'b0, deriv_gain_ff}) * s1_delta_ff;
      im_in = 33'(integ_gain_ff) * 33'(s1_abs_ff);
   end

   always_ff @(posedge clock) begin
      if (move[1]) begin
         s2_p_ff <= p_full[31:0];
         s2_dp_ff <= dp_full[31:0];
         s2_im_ff <= im_in;
         s2_neg_ff <= s1_neg_ff;
         spd_ff[2] <= spd_ff[1];
      end
   end

   // Stage 3: D term times 100, P plus D, and the quotient estimate.
   logic [31:0] d100, pd_in;
   logic [58:0] qprod;
   logic [31:0] s3_pd_ff;
   logic [26:0] s3_qest_ff;
   logic [32:0] s3_im_ff;
   logic        s3_neg_ff;

   always_comb begin
      d100 = (s2_dp_ff << 6) + (s2_dp_ff << 5) + (s2_dp_ff << 2);
      pd_in = s2_p_ff + d100;
      qprod = 59'(s2_im_ff) * 59'(DIV100_RECIP);
   end

   always_ff @(posedge clock) begin
      if (move[2]) begin
         s3_pd_ff <= pd_in;
         s3_qest_ff <= qprod[58:32];
         s3_im_ff <= s2_im_ff;
         s3_neg_ff <= s2_neg_ff;
         spd_ff[3] <= spd_ff[2];
      end
   end

   // Stage 4: correct the quotient and apply the sign (truncation toward zero).
   // The estimate is at most three low, so the remainder fits in nine bits.
   logic [33:0] qx100;
   logic [8:0]  rem9;
   logic [26:0] quot;
   logic [31:0] quot_ext, inc_in;
   logic [31:0] s4_inc_ff, s4_pd_ff;

   always_comb begin
      qx100 = 34'(s3_qest_ff) * HUNDRED;
      rem9 = s3_im_ff[8:0] - qx100[8:0];
      quot = s3_qest_ff + 27'(rem9 >= 9'd100) + 27'(rem9 >= 9'd200)
             + 27'(rem9 >= 9'd300);
      quot_ext = 32'(quot);
      inc_in = s3_neg_ff ? (~quot_ext + 32'd1) : quot_ext;
   end

   always_ff @(posedge clock) begin
      if (move[3]) begin
         s4_inc_ff <= inc_in;
         s4_pd_ff <= s3_pd_ff;
         spd_ff[4] <= spd_ff[3];
      end
   end

   // Stage 5: integral and control accumulator updates.
   logic [31:0] isum_ff, isum_in, acc_ff, acc_in;
   logic [15:0] s5_sample_ff;

   always_comb begin
      isum_in = isum_ff + s4_inc_ff;
      acc_in = acc_ff + s4_pd_ff + isum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         isum_ff <= '0;
         acc_ff <= '0;
      end else if (move[4]) begin
         isum_ff <= isum_in;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move[4]) begin
         s5_sample_ff <= acc_in[15:0];
         spd_ff[5] <= spd_ff[4];
      end
   end

   // Stage 6: averaging window as a shift line with a running sum.
   logic [15:0]      taps_ff [WINDOW_LEN];
   logic [SUM_W-1:0] wsum_ff, wsum_in;
   logic [SUM_W-1:0] s6_sum_ff;

   assign wsum_in = wsum_ff + SUM_W'(s5_sample_ff) - SUM_W'(taps_ff[WINDOW_LEN-1]);

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff <= '0;
         for (int k = 0; k < WINDOW_LEN; k++) begin
            taps_ff[k] <= '0;
         end
      end else if (move[5]) begin
         wsum_ff <= wsum_in;
         taps_ff[0] <= s5_sample_ff;
         for (int k = 1; k < WINDOW_LEN; k++) begin
            taps_ff[k] <= taps_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move[5]) begin
         s6_sum_ff <= wsum_in;
         spd_ff[6] <= spd_ff[5];
      end
   end

   // Stage 7: mean estimate by reciprocal; it is exact or one low.
   logic [PROD_W-1:0] wprod;
   logic [15:0]       s7_qest_ff;
   logic [SUM_W-1:0]  s7_sum_ff;

   assign wprod = PROD_W'(s6_sum_ff) * PROD_W'(RECIP_W);

   always_ff @(posedge clock) begin
      if (move[6]) begin
         s7_qest_ff <= wprod[SUM_W+15:SUM_W];
         s7_sum_ff <= s6_sum_ff;
         spd_ff[7] <= spd_ff[6];
      end
   end

   // Stage 8: mean correction, clamp and enable into the result register.
   logic [REM_W-1:0]  wq_lo, wrem;
   logic [DUTY_W-1:0] mean, duty_in;
   logic              en_in;
   logic [DUTY_W-1:0] duty_ff;
   logic              en_ff;
   logic [SPEED_W-1:0] speed_out_ff;

   always_comb begin
      wq_lo = REM_W'(s7_qest_ff) * WL_C;
      wrem = s7_sum_ff[REM_W-1:0] - wq_lo;
      mean = s7_qest_ff + DUTY_W'(wrem >= WL_C);
      en_in = (mean != '0) && (mean < DRIVE_PERIOD);
      duty_in = (mean >= DRIVE_PERIOD) ? (DRIVE_PERIOD - 16'd1) : mean;
   end

   always_ff @(posedge clock) begin
      if (move[7]) begin
         duty_ff <= duty_in;
         en_ff <= en_in;
         speed_out_ff <= spd_ff[7];
      end
   end

   assign rsp_chan.valid = v_ff[NSTG-1];
   assign rsp_chan.duty_level = duty_ff;
   assign rsp_chan.drive_enable = en_ff;
   assign rsp_chan.measured_speed = speed_out_ff;

endmodule

[hdl/ecp_checker.sv]
module ecp_checker import ecp_pkg::*; #(
   parameter logic [DUTY_W-1:0] DRIVE_PERIOD = DRIVE_PERIOD_DEF
) (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [DUTY_W-1:0]  duty_level,
   input logic               drive_enable,
   input logic [SPEED_W-1:0] measured_speed
);

   // A blocked result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(duty_level)
      && $stable(drive_enable) && $stable(measured_speed))
      else $error("result changed while stalled");

   // The clamp keeps the duty level below the period.
   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> duty_level < DRIVE_PERIOD)
      else $error("duty level outside the period");

   // Enable means a nonzero mean that passed through unclamped.
   a_enable_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && drive_enable |-> duty_level != '0)
      else $error("drive enabled at zero duty");

   // Enable low with a nonzero duty can only be saturation.
   a_saturation: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !drive_enable && duty_level != '0
      |-> duty_level == DRIVE_PERIOD - 16'd1)
      else $error("disabled result is neither zero nor saturated");

   // No result is offered right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind encoder_pid_speed_controller_top ecp_checker #(
   .DRIVE_PERIOD(DRIVE_PERIOD)
) u_ecp_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .duty_level(rsp_chan.duty_level),
   .drive_enable(rsp_chan.drive_enable),
   .measured_speed(rsp_chan.measured_speed)
);

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import ecp_pkg::*;

   // Register index that the block does not decode; writes to it must be dropped.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 2'd3;
   localparam int PIPE_DEPTH = 9;
   localparam int SETTLE_CYCLES = PIPE_DEPTH + 6;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_TICKS = 235;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic               enable;
      logic [SPEED_W-1:0] speed;
   } drive_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0]    csr_wdata;

   ecp_req_if req_bus ();
   ecp_rsp_if rsp_bus ();

   encoder_pid_speed_controller_top u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus)
   );

   // Free-running 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Controller state mirrored by the predictor.
   logic [GAIN_W-1:0]  gain_p = PROP_GAIN_RST;
   logic [GAIN_W-1:0]  gain_i = INTEG_GAIN_RST;
   logic [GAIN_W-1:0]  gain_d = DERIV_GAIN_RST;
   logic [COUNT_W-1:0] last_count = '0;
   longint             last_error = 0;
   logic [31:0]        integ_acc = '0;
   logic [31:0]        ctrl_acc = '0;
   logic [DUTY_W-1:0]  avg_win [WINDOW_LEN_DEF];
   int                 win_pos = 0;

   drive_result_type drive_expect_q [$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_len = 0;
   int hold_req_id = 0;
   int ticks_sent = 0;
   int results_checked = 0;
   int mismatch_count = 0;
   int gain_settings = 1;
   int cycle_count = 0;

   initial begin
      foreach (avg_win[k]) avg_win[k] = '0;
   end

   // Work out the drive result of one tick and queue it.
   task automatic predict_drive(input logic [COUNT_W-1:0] cnt,
                                input logic [TARGET_W-1:0] tgt);
      logic [COUNT_W-1:0] delta;
      logic [SPEED_W-1:0] mag;
      logic [SPEED_W-1:0] speed;
      longint tgt_l, speed_l, gp, gi, gd, err, p_t, d_t, i_t;
      int unsigned total;
      int unsigned mean;
      drive_result_type res;
      delta = cnt - last_count;
      // A difference of exactly half the range still counts as 32768.
      mag = delta[COUNT_W-1] ? (17'h10000 - {1'b0, delta}) : {1'b0, delta};
      speed = mag * 17'd3;
      last_count = cnt;
      tgt_l = tgt;
      speed_l = speed;
      gp = gain_p;
      gi = gain_i;
      gd = gain_d;
      err = tgt_l - speed_l;
      p_t = gp * err;
      d_t = gd * (err - last_error) * 100;
      i_t = (gi * err * 10) / 1000;
      integ_acc = integ_acc + i_t[31:0];
      ctrl_acc = ctrl_acc + p_t[31:0] + d_t[31:0] + integ_acc;
      last_error = err;
      // Only the low half of the accumulator enters the averaging window.
      avg_win[win_pos] = ctrl_acc[15:0];
      win_pos = (win_pos + 1) % WINDOW_LEN_DEF;
      total = 0;
      foreach (avg_win[k]) total += avg_win[k];
      mean = total / WINDOW_LEN_DEF;
      res.enable = (mean > 0) && (mean < DRIVE_PERIOD_DEF);
      res.duty = (mean >= DRIVE_PERIOD_DEF) ? DRIVE_PERIOD_DEF - 16'd1 : mean[DUTY_W-1:0];
      res.speed = speed;
      drive_expect_q.push_back(res);
   endtask

   // Offer one tick, with random idle cycles ahead of it, and wait for acceptance.
   task automatic send_tick(input logic [COUNT_W-1:0] cnt, input logic [TARGET_W-1:0] tgt);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.encoder_count <= cnt;
      req_bus.target_speed <= tgt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_drive(cnt, tgt);
      ticks_sent++;
      @(negedge clock);
   endtask

   // Stop offering, then wait until every result is back and the pipeline is empty.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (drive_expect_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // One register write; the predictor follows the same decode.
   task automatic write_gain(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_PROP_GAIN: gain_p = val;
         REG_INTEG_GAIN: gain_i = val;
         REG_DERIV_GAIN: gain_d = val;
         default: ;
      endcase
   endtask

   task automatic write_all_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kd);
      write_gain(REG_PROP_GAIN, kp);
      write_gain(REG_INTEG_GAIN, ki);
      write_gain(REG_DERIV_GAIN, kd);
      gain_settings++;
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return GAIN_W'($urandom_range(0, 31));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, plus a long hold whenever one is requested.
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req_id != hold_seen) begin
            hold_seen = hold_req_id;
            hold_left = hold_len;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (drive_expect_q.size() == 0) begin
            $error("Result arrived with no tick outstanding");
            mismatch_count++;
         end else begin
            want = drive_expect_q.pop_front();
            results_checked++;
            if (rsp_bus.duty_level !== want.duty) begin
               $error("duty_level: expected %0d, actual %0d", want.duty, rsp_bus.duty_level);
               mismatch_count++;
            end
            if (rsp_bus.drive_enable !== want.enable) begin
               $error("drive_enable: expected %0d, actual %0d", want.enable,
                      rsp_bus.drive_enable);
               mismatch_count++;
            end
            if (rsp_bus.measured_speed !== want.speed) begin
               $error("measured_speed: expected %0d, actual %0d", want.speed,
                      rsp_bus.measured_speed);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run timed out with %0d results outstanding", drive_expect_q.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Zero ticks with the reset gains: everything stays at rest.
   task automatic test_reset_defaults();
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h0000, 16'h0000);
      wait_idle();
   endtask

   // Drive the window mean above the drive period, then back down through the enable range.
   task automatic test_drive_clamp();
      write_gain(REG_PROP_GAIN, 16'd1);
      send_tick(16'h0000, 16'd65000);
      repeat (7) send_tick(16'h0000, 16'd0);
      send_tick(16'h0000, 16'd536);
      repeat (3) send_tick(16'h0000, 16'd0);
      wait_idle();
   endtask

   // A write to an undecoded index must leave the gains alone.
   task automatic test_unknown_index();
      write_gain(REG_UNUSED, 16'hFFFF);
      send_tick(16'h0000, 16'd1234);
      wait_idle();
   endtask

   // Half-range and wrapping count jumps with full gains, so the accumulator overflows.
   task automatic test_count_jumps();
      write_all_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_tick(16'h8000, 16'hFFFF);
      send_tick(16'h0000, 16'h0000);
      send_tick(16'h7FFF, 16'hFFFF);
      send_tick(16'hFFFF, 16'h0000);
      send_tick(16'h0000, 16'hFFFF);
      wait_idle();
   endtask

   // Hold the output off long enough that the pipeline fills and stalls the input.
   task automatic test_output_backpressure();
      logic [COUNT_W-1:0] cnt;
      cnt = last_count;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      write_all_gains(16'd3, 16'd40, 16'd1);
      hold_len = 80;
      hold_req_id++;
      repeat (30) begin
         cnt = cnt + COUNT_W'($urandom_range(0, 400));
         send_tick(cnt, 16'($urandom_range(0, 1500)));
      end
      wait_idle();
   endtask

   // Random ticks under each idling mode and a fresh gain setting per phase.
   task automatic test_random_ticks();
      int send_pct [4] = '{0, 78, 0, 32};
      int stall_pct [4] = '{0, 0, 78, 32};
      logic [COUNT_W-1:0] cnt;
      logic [TARGET_W-1:0] tgt;
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 0) write_all_gains(16'd0, 16'd0, 16'd0);
         else if (ph == 1) write_all_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
         else write_all_gains(pick_gain(), pick_gain(), pick_gain());
         send_idle_pct = send_pct[ph % 4];
         rsp_stall_pct = stall_pct[ph % 4];
         cnt = last_count;
         for (int n = 0; n < PHASE_TICKS; n++) begin
            // Mostly a plausibly moving encoder; the rest arbitrary counts and targets.
            if ($urandom_range(0, 99) < 70) begin
               cnt = cnt + COUNT_W'($urandom_range(0, 2000)) - COUNT_W'(1000);
               tgt = TARGET_W'($urandom_range(0, 6000));
            end else begin
               cnt = COUNT_W'($urandom);
               tgt = TARGET_W'($urandom);
            end
            send_tick(cnt, tgt);
            // Occasional full-speed stretches inside the idle phases.
            if ((n % 60) == 59) send_idle_pct = (send_idle_pct == 0) ? send_pct[ph % 4] : 0;
         end
         wait_idle();
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Test sequence.
   initial begin
      req_bus.valid = 1'b0;
      req_bus.encoder_count = '0;
      req_bus.target_speed = '0;
      csr_we = 1'b0;
      csr_index = REG_PROP_GAIN;
      csr_wdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_drive_clamp();
      test_unknown_index();
      test_count_jumps();
      test_output_backpressure();
      test_random_ticks();

      wait_idle();
      $display("Sent %0d ticks and checked %0d results over %0d gain settings,",
               ticks_sent, results_checked, gain_settings);
      $display("with sender idling, receiver stalls and one long output hold.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
